// ----- hw/rtl/hsvt_pkg.sv -----
// Shared constants and types for the HSV threshold and row gap fill block.
package hsvt_pkg;

  localparam int WINDOW_DEF = 32;
  localparam int COMP_W     = 8;
  localparam int GAP_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX  = 4'd7;

  localparam logic [COMP_W-1:0] HUE_LOW_RST  = 8'd0;
  localparam logic [COMP_W-1:0] HUE_HIGH_RST = 8'd179;
  localparam logic [COMP_W-1:0] SAT_LOW_RST  = 8'd0;
  localparam logic [COMP_W-1:0] SAT_HIGH_RST = 8'd255;
  localparam logic [COMP_W-1:0] VAL_LOW_RST  = 8'd0;
  localparam logic [COMP_W-1:0] VAL_HIGH_RST = 8'd255;
  localparam logic [GAP_W-1:0]  GAP_MIN_RST  = 6'd10;
  localparam logic [GAP_W-1:0]  GAP_MAX_RST  = 6'd20;

  typedef struct packed {
    logic [COMP_W-1:0] hue_low;
    logic [COMP_W-1:0] hue_high;
    logic [COMP_W-1:0] sat_low;
    logic [COMP_W-1:0] sat_high;
    logic [COMP_W-1:0] val_low;
    logic [COMP_W-1:0] val_high;
    logic [GAP_W-1:0]  gap_min;
    logic [GAP_W-1:0]  gap_max;
  } cfg_t;

endpackage

// ----- hw/rtl/hsvt_intf.sv -----
// Handshake interfaces for the pixel, mask and configuration channels.
interface hsvt_pix_if;
  logic                        valid;
  logic                        ready;
  logic [hsvt_pkg::COMP_W-1:0] hue;
  logic [hsvt_pkg::COMP_W-1:0] sat;
  logic [hsvt_pkg::COMP_W-1:0] val;
  logic                        row_end;

  modport source (output valid, hue, sat, val, row_end, input ready);
  modport sink   (input valid, hue, sat, val, row_end, output ready);
endinterface

interface hsvt_mask_if;
  logic valid;
  logic ready;
  logic mask_bit;
  logic row_last;

  modport source (output valid, mask_bit, row_last, input ready);
  modport sink   (input valid, mask_bit, row_last, output ready);
endinterface

interface hsvt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hsvt_pkg::CFG_IDX_W-1:0]  index;
  logic [hsvt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/hsvt_cfg_regs.sv -----
// Configuration register file for the threshold bounds and gap limits.
module hsvt_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  hsvt_cfg_if.sink         cfg,
  output hsvt_pkg::cfg_t   cfg_o
);

  hsvt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        hsvt_pkg::REG_HUE_LOW:  cfg_d.hue_low  = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_HUE_HIGH: cfg_d.hue_high = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_SAT_LOW:  cfg_d.sat_low  = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_SAT_HIGH: cfg_d.sat_high = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_VAL_LOW:  cfg_d.val_low  = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_VAL_HIGH: cfg_d.val_high = cfg.data[hsvt_pkg::COMP_W-1:0];
        hsvt_pkg::REG_GAP_MIN:  cfg_d.gap_min  = cfg.data[hsvt_pkg::GAP_W-1:0];
        hsvt_pkg::REG_GAP_MAX:  cfg_d.gap_max  = cfg.data[hsvt_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= hsvt_pkg::HUE_LOW_RST;
      cfg_q.hue_high <= hsvt_pkg::HUE_HIGH_RST;
      cfg_q.sat_low  <= hsvt_pkg::SAT_LOW_RST;
      cfg_q.sat_high <= hsvt_pkg::SAT_HIGH_RST;
      cfg_q.val_low  <= hsvt_pkg::VAL_LOW_RST;
      cfg_q.val_high <= hsvt_pkg::VAL_HIGH_RST;
      cfg_q.gap_min  <= hsvt_pkg::GAP_MIN_RST;
      cfg_q.gap_max  <= hsvt_pkg::GAP_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/hsvt_front.sv -----
// Front end: thresholds each pixel, tracks the anchor, fills gaps in the delay line.
module hsvt_front #(
  parameter int WINDOW = hsvt_pkg::WINDOW_DEF,
  parameter int DW     = $clog2(WINDOW + 2),
  parameter int LW     = WINDOW + 1,
  parameter int JOB_W  = 1 + DW + LW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsvt_pix_if.sink             pix,
  input  hsvt_pkg::cfg_t       cfg_i,
  output logic                 push_o,
  output logic [JOB_W-1:0]     push_data_o,
  input  logic                 push_ready_i
);

  localparam int HW   = $clog2(WINDOW + 1);
  localparam int CMPW = (DW > hsvt_pkg::GAP_W) ? DW : hsvt_pkg::GAP_W;

  // A job is either one aged-out bit or a whole row flush, oldest bit at index 0.
  typedef struct packed {
    logic          row;
    logic [DW-1:0] cnt;
    logic [LW-1:0] bits;
  } job_t;

  logic [LW-1:0] line_q, line_d;
  logic [HW-1:0] held_q, held_d;
  logic          anchor_q, anchor_d;
  logic [DW-1:0] dist_q, dist_d;

  logic          accept, marked, fill, emit;
  logic [DW-1:0] held_ext, held_inc, dist_inc, fill_start;
  logic [LW-1:0] below_held, below_start, append_bit, line_new;
  job_t          job;

  assign accept   = pix.valid && pix.ready;
  assign pix.ready = push_ready_i;

  assign marked = (pix.hue >= cfg_i.hue_low) && (pix.hue <= cfg_i.hue_high) &&
                  (pix.sat >= cfg_i.sat_low) && (pix.sat <= cfg_i.sat_high) &&
                  (pix.val >= cfg_i.val_low) && (pix.val <= cfg_i.val_high);

  assign held_ext = DW'(held_q);
  assign held_inc = held_ext + DW'(1);
  assign dist_inc = (anchor_q && (dist_q != DW'(WINDOW + 1))) ? dist_q + DW'(1) : dist_q;

  assign fill = marked && anchor_q &&
                (CMPW'(dist_inc) > CMPW'(cfg_i.gap_min)) &&
                (CMPW'(dist_inc) < CMPW'(cfg_i.gap_max)) &&
                (dist_inc <= DW'(WINDOW));

  // The fill covers the dist_inc bits just below the newest slot, clipped at the oldest.
  assign fill_start = (dist_inc >= held_ext) ? '0 : held_ext - dist_inc;

  always_comb begin
    for (int i = 0; i < LW; i++) begin
      below_held[i]  = (DW'(i) < held_ext);
      below_start[i] = (DW'(i) < fill_start);
      append_bit[i]  = (DW'(i) == held_ext) && marked;
    end
  end

  assign line_new = line_q | append_bit | (fill ? (below_held & ~below_start) : '0);
  assign emit     = pix.row_end || (held_inc == DW'(WINDOW + 1));

  always_comb begin
    job.row  = pix.row_end;
    job.cnt  = pix.row_end ? held_inc : DW'(1);
    job.bits = pix.row_end ? line_new : LW'(line_new[0]);
  end

  assign push_o      = accept && emit;
  assign push_data_o = job;

  always_comb begin
    line_d   = line_q;
    held_d   = held_q;
    anchor_d = anchor_q;
    dist_d   = dist_q;
    if (accept) begin
      if (marked && !anchor_q) begin
        anchor_d = 1'b1;
        dist_d   = '0;
      end else if (marked && !fill) begin
        dist_d = '0;
      end else begin
        dist_d = dist_inc;
      end
      if (pix.row_end) begin
        line_d   = '0;
        held_d   = '0;
        anchor_d = 1'b0;
        dist_d   = '0;
      end else if (emit) begin
        line_d = line_new >> 1;
        held_d = HW'(WINDOW);
      end else begin
        line_d = line_new;
        held_d = held_inc[HW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= '0;
      held_q   <= '0;
      anchor_q <= 1'b0;
      dist_q   <= '0;
    end else begin
      line_q   <= line_d;
      held_q   <= held_d;
      anchor_q <= anchor_d;
      dist_q   <= dist_d;
    end
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(held_q) <= DW'(WINDOW))
    else $error("delay line holds more bits than the window");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pix.row_end |=> held_q == '0 && !anchor_q && dist_q == '0)
    else $error("row state not cleared after row end");

  a_slots_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q & ~below_held) == '0)
    else $error("delay line has bits set beyond the held count");

endmodule

// ----- hw/rtl/hsvt_queue.sv -----
// Short job queue between the front and back ends.
module hsvt_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = hsvt_pkg::QDEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              nonempty_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  assign ready_o    = (cnt_q != CW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into a full job queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("pop from an empty job queue");

endmodule

// ----- hw/rtl/hsvt_back.sv -----
// Back end: serializes queued jobs into mask bits, oldest first.
module hsvt_back #(
  parameter int WINDOW = hsvt_pkg::WINDOW_DEF,
  parameter int DW     = $clog2(WINDOW + 2),
  parameter int LW     = WINDOW + 1,
  parameter int JOB_W  = 1 + DW + LW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nonempty_i,
  input  logic [JOB_W-1:0] job_i,
  output logic             pop_o,
  hsvt_mask_if.source      mask
);

  typedef struct packed {
    logic          row;
    logic [DW-1:0] cnt;
    logic [LW-1:0] bits;
  } job_t;

  job_t          job;
  logic [LW-1:0] bits_q, bits_d;
  logic [DW-1:0] rem_q, rem_d;
  logic          row_q, row_d;
  logic          fire;

  assign job  = job_i;
  assign fire = mask.valid && mask.ready;

  assign mask.valid    = (rem_q != '0);
  assign mask.mask_bit = bits_q[0];
  assign mask.row_last = row_q && (rem_q == DW'(1));

  // The next job loads as the last bit of the current one leaves.
  assign pop_o = nonempty_i && ((rem_q == '0) || (fire && (rem_q == DW'(1))));

  always_comb begin
    bits_d = bits_q;
    rem_d  = rem_q;
    row_d  = row_q;
    if (pop_o) begin
      bits_d = job.bits;
      rem_d  = job.cnt;
      row_d  = job.row;
    end else if (fire) begin
      bits_d = bits_q >> 1;
      rem_d  = rem_q - DW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      row_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      row_q <= row_d;
    end
  end

  a_single_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !row_q |-> rem_q <= DW'(1))
    else $error("aged-out job carries more than one bit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= DW'(WINDOW + 1))
    else $error("job longer than the delay line");

endmodule

// ----- hw/rtl/hsv_threshold_row_gap_fill.sv -----
// HSV in-range threshold with per-row gap fill, top level.
//
// Pixels enter on pix_i in raster order, one transaction per pixel, with
// row_end set on the last pixel of each row. Mask bits leave on mask_o, one
// transaction per bit, with row_last set on the final bit of a row. Bounds
// and gap limits are to be written on cfg_i only while the block is idle,
// which the block itself does not enforce; cfg_i.ready is always high.
// A pixel's bit is held in a WINDOW-deep delay line so that a later in-range
// pixel can fill the gap behind it. Once the line is full, every pixel pushes
// out the oldest bit; a row end pushes out the whole line at once.
// Throughput is one pixel per cycle while pix_i.ready is high. A bit that a
// transaction releases is written into the job queue and then loaded into
// the output register before it appears on mask_o.
// A row flush of n bits occupies the output until all n bits have left; the
// two-entry job queue lets the next row's pixels enter meanwhile, and
// pix_i.ready drops only when both queue entries are taken.
// When mask_o is stalled the output bit and row_last hold; the queue fills and
// then pix_i.ready goes low. Reset empties the delay line, the queue and the
// output, and loads the default bounds.
module hsv_threshold_row_gap_fill #(
  parameter int WINDOW = hsvt_pkg::WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvt_pix_if.sink    pix_i,
  hsvt_mask_if.source mask_o,
  hsvt_cfg_if.sink    cfg_i
);

  localparam int DW    = $clog2(WINDOW + 2);
  localparam int LW    = WINDOW + 1;
  localparam int JOB_W = 1 + DW + LW;

  hsvt_pkg::cfg_t   cfg;
  logic             push, push_ready, pop, nonempty;
  logic [JOB_W-1:0] push_data, pop_data;

  hsvt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  hsvt_front #(
    .WINDOW (WINDOW),
    .DW     (DW),
    .LW     (LW),
    .JOB_W  (JOB_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix_i),
    .cfg_i        (cfg),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  hsvt_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (hsvt_pkg::QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (push_ready),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_data_o  (pop_data)
  );

  hsvt_back #(
    .WINDOW (WINDOW),
    .DW     (DW),
    .LW     (LW),
    .JOB_W  (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (nonempty),
    .job_i      (pop_data),
    .pop_o      (pop),
    .mask       (mask_o)
  );

endmodule
